// ===== sv/rsi_pkg.sv =====
// Shared widths, types and constants of the ray-sphere intersection core.
package rsi_pkg;

   localparam int unsigned COORD_W   = 32;  // Q16.16 coordinate
   localparam int unsigned DIR_W     = 18;  // Q1.16 direction component
   localparam int unsigned R2_W      = 63;  // Q31.32 squared radius
   localparam int unsigned DIST_W    = 31;  // Q15.16 distance
   localparam int unsigned OC_W      = 33;  // center minus origin
   localparam int unsigned SQ_W      = 66;  // one squared component
   localparam int unsigned L2_W      = 68;  // squared length of oc
   localparam int unsigned PR_W      = 51;  // one oc * dir product
   localparam int unsigned DOT_W     = 53;  // sum of three products
   localparam int unsigned TMAG_W    = 35;  // rounded |tca|
   localparam int unsigned TCA2_W    = 70;  // tca squared
   localparam int unsigned RAD_W     = 72;  // radicand, even width
   localparam int unsigned ROOT_W    = RAD_W / 2;
   localparam int unsigned REM_W     = ROOT_W + 2;
   localparam int unsigned TCA_W     = TMAG_W + 1;
   localparam int unsigned SDIST_W   = ROOT_W + 2;
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Z = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS2  = 2'd3;

   localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

   // Per-ray information that rides along the square-root pipeline.
   typedef struct packed {
      logic                    miss;
      logic                    in_sphere;
      logic signed [TCA_W-1:0] tca;
   } rsi_side_type;

endpackage

// ===== sv/rsi_isqrt.sv =====
// Pipelined floor square root, one result bit per register stage.
module rsi_isqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         enable,
   input  logic                         in_valid,
   input  logic [rsi_pkg::RAD_W-1:0]    in_radicand,
   input  rsi_pkg::rsi_side_type        in_side,
   output logic                         out_valid,
   output logic [rsi_pkg::ROOT_W-1:0]   out_root,
   output rsi_pkg::rsi_side_type        out_side
);
   import rsi_pkg::*;

   logic                valid_ff [0:ROOT_W];
   logic [RAD_W-1:0]    rad_ff   [0:ROOT_W];
   logic [REM_W-1:0]    rem_ff   [0:ROOT_W];
   logic [ROOT_W-1:0]   root_ff  [0:ROOT_W];
   rsi_side_type        side_ff  [0:ROOT_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (enable) begin
         valid_ff[0] <= in_valid;
      end
      if (enable) begin
         rad_ff[0]  <= in_radicand;
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
         side_ff[0] <= in_side;
      end
   end

   for (genvar k = 0; k < ROOT_W; k++) begin : g_step
      logic [REM_W+1:0]  cur;
      logic [REM_W+1:0]  trial;
      logic              ge;
      logic [REM_W+1:0]  diff;

      always_comb begin
         cur   = {rem_ff[k], rad_ff[k][RAD_W-1 -: 2]};
         trial = {2'b00, root_ff[k], 2'b01};
         ge    = (cur >= trial);
         diff  = ge ? (cur - trial) : cur;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (enable) begin
            valid_ff[k+1] <= valid_ff[k];
         end
         if (enable) begin
            rad_ff[k+1]  <= {rad_ff[k][RAD_W-3:0], 2'b00};
            rem_ff[k+1]  <= diff[REM_W-1:0];
            root_ff[k+1] <= {root_ff[k][ROOT_W-2:0], ge};
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   assign out_valid = valid_ff[ROOT_W];
   assign out_root  = root_ff[ROOT_W];
   assign out_side  = side_ff[ROOT_W];

endmodule

// ===== sv/ray_sphere_intersection_core.sv =====
// Top level of the ray-sphere intersection core: geometry pipeline and result stage.
// Ray-sphere intersection core. Each req_ transaction carries one ray (Q16.16
// origin, Q1.16 unit direction) and produces exactly one rsp_ transaction: hit,
// Q15.16 distance to the near surface (far surface when the origin lies
// inside), and a saturated flag when the distance was clamped. A new ray is
// taken every cycle while req_stall is low. The pipeline has six geometry
// stages, the square-root input register plus 36 square-root stages at one
// root bit each, and one result register. The whole pipeline advances as one:
// req_stall rises only while a result sits in the output register with
// rsp_stall high. The sphere (center, squared radius) lives in csr_
// registers; write them only while no ray is in flight. csr_ready is always high.
module ray_sphere_intersection_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [rsi_pkg::COORD_W-1:0]    req_origin_x,
   input  logic signed [rsi_pkg::COORD_W-1:0]    req_origin_y,
   input  logic signed [rsi_pkg::COORD_W-1:0]    req_origin_z,
   input  logic signed [rsi_pkg::DIR_W-1:0]      req_dir_x,
   input  logic signed [rsi_pkg::DIR_W-1:0]      req_dir_y,
   input  logic signed [rsi_pkg::DIR_W-1:0]      req_dir_z,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_hit,
   output logic [rsi_pkg::DIST_W-1:0]            rsp_distance,
   output logic                                  rsp_saturated,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [rsi_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [rsi_pkg::R2_W-1:0]              csr_data
);
   import rsi_pkg::*;

   // ---------------------------------------------------------------- config
   logic signed [COORD_W-1:0] center_x_ff, center_y_ff, center_z_ff;
   logic [R2_W-1:0]           radius2_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         center_z_ff <= 32'sd6553600;          // 100.0
         radius2_ff  <= 63'd4294967296;        // 1.0
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_CENTER_X: center_x_ff <= csr_data[COORD_W-1:0];
            CSR_CENTER_Y: center_y_ff <= csr_data[COORD_W-1:0];
            CSR_CENTER_Z: center_z_ff <= csr_data[COORD_W-1:0];
            CSR_RADIUS2:  radius2_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // -------------------------------------------------------- flow control
   // Advance every stage together unless the output holds an untaken result.
   logic adv;
   logic rsp_valid_ff;
   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   // Stage 1: oc = center - origin.
   logic                      s1_valid_ff;
   logic signed [OC_W-1:0]    s1_oc_ff [0:2];
   logic signed [DIR_W-1:0]   s1_d_ff  [0:2];

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else if (adv) s1_valid_ff <= req_valid;
      if (adv) begin
         s1_oc_ff[0] <= OC_W'(center_x_ff) - OC_W'(req_origin_x);
         s1_oc_ff[1] <= OC_W'(center_y_ff) - OC_W'(req_origin_y);
         s1_oc_ff[2] <= OC_W'(center_z_ff) - OC_W'(req_origin_z);
         s1_d_ff[0]  <= req_dir_x;
         s1_d_ff[1]  <= req_dir_y;
         s1_d_ff[2]  <= req_dir_z;
      end
   end

   // Stage 2: squares of oc and products with the direction.
   logic                     s2_valid_ff;
   logic [SQ_W-1:0]          s2_sq_ff [0:2];
   logic signed [PR_W-1:0]   s2_pr_ff [0:2];
   logic [OC_W-1:0]          oc_mag [0:2];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         oc_mag[i] = s1_oc_ff[i][OC_W-1] ? OC_W'(-s1_oc_ff[i]) : OC_W'(s1_oc_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s2_valid_ff <= 1'b0;
      else if (adv) s2_valid_ff <= s1_valid_ff;
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            s2_sq_ff[i] <= SQ_W'(oc_mag[i]) * SQ_W'(oc_mag[i]);
            s2_pr_ff[i] <= PR_W'(s1_oc_ff[i]) * PR_W'(s1_d_ff[i]);
         end
      end
   end

   // Stage 3: l2oc and the dot product.
   logic                     s3_valid_ff;
   logic [L2_W-1:0]          s3_l2oc_ff;
   logic signed [DOT_W-1:0]  s3_dot_ff;

   always_ff @(posedge clock) begin
      if (reset) s3_valid_ff <= 1'b0;
      else if (adv) s3_valid_ff <= s2_valid_ff;
      if (adv) begin
         s3_l2oc_ff <= L2_W'(s2_sq_ff[0]) + L2_W'(s2_sq_ff[1]) + L2_W'(s2_sq_ff[2]);
         s3_dot_ff  <= DOT_W'(s2_pr_ff[0]) + DOT_W'(s2_pr_ff[1]) + DOT_W'(s2_pr_ff[2]);
      end
   end

   // Stage 4: round the dot product to tca, test whether the origin is inside.
   logic                     s4_valid_ff;
   logic [TMAG_W-1:0]        s4_tmag_ff;
   logic                     s4_neg_ff;
   logic                     s4_inside_ff;
   logic [L2_W-1:0]          s4_l2oc_ff;
   logic [DOT_W-1:0]         dot_mag;
   logic [DOT_W-1:0]         dot_rnd;

   always_comb begin
      dot_mag = s3_dot_ff[DOT_W-1] ? DOT_W'(-s3_dot_ff) : DOT_W'(s3_dot_ff);
      dot_rnd = dot_mag + DOT_W'(32768);
   end

   always_ff @(posedge clock) begin
      if (reset) s4_valid_ff <= 1'b0;
      else if (adv) s4_valid_ff <= s3_valid_ff;
      if (adv) begin
         s4_tmag_ff   <= dot_rnd[16 +: TMAG_W];
         s4_neg_ff    <= s3_dot_ff[DOT_W-1];
         s4_inside_ff <= (s3_l2oc_ff < L2_W'(radius2_ff));
         s4_l2oc_ff   <= s3_l2oc_ff;
      end
   end

   // Stage 5: tca squared.
   logic                     s5_valid_ff;
   logic [TCA2_W-1:0]        s5_tca2_ff;
   logic [TMAG_W-1:0]        s5_tmag_ff;
   logic                     s5_neg_ff;
   logic                     s5_inside_ff;
   logic [L2_W-1:0]          s5_l2oc_ff;

   always_ff @(posedge clock) begin
      if (reset) s5_valid_ff <= 1'b0;
      else if (adv) s5_valid_ff <= s4_valid_ff;
      if (adv) begin
         s5_tca2_ff   <= TCA2_W'(s4_tmag_ff) * TCA2_W'(s4_tmag_ff);
         s5_tmag_ff   <= s4_tmag_ff;
         s5_neg_ff    <= s4_neg_ff;
         s5_inside_ff <= s4_inside_ff;
         s5_l2oc_ff   <= s4_l2oc_ff;
      end
   end

   // Stage 6: squared half-chord and the hit/miss decision.
   logic                     s6_valid_ff;
   logic [RAD_W-1:0]         s6_l2hc_ff;
   rsi_side_type             s6_side_ff;
   logic [RAD_W-1:0]         hc_sum;
   logic                     pos_hc;
   rsi_side_type             side_in;

   always_comb begin
      hc_sum            = RAD_W'(radius2_ff) + RAD_W'(s5_tca2_ff);
      pos_hc            = (RAD_W'(s5_l2oc_ff) < hc_sum);
      side_in.in_sphere = s5_inside_ff;
      side_in.miss      = !s5_inside_ff && (s5_neg_ff || !pos_hc);
      side_in.tca       = s5_neg_ff ? -TCA_W'(s5_tmag_ff) : TCA_W'(s5_tmag_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) s6_valid_ff <= 1'b0;
      else if (adv) s6_valid_ff <= s5_valid_ff;
      if (adv) begin
         s6_l2hc_ff <= pos_hc ? (hc_sum - RAD_W'(s5_l2oc_ff)) : '0;
         s6_side_ff <= side_in;
      end
   end

   // Square root of the half-chord.
   logic                     sq_valid;
   logic [ROOT_W-1:0]        sq_root;
   rsi_side_type             sq_side;

   rsi_isqrt u_isqrt (
      .clock       (clock),
      .reset       (reset),
      .enable      (adv),
      .in_valid    (s6_valid_ff),
      .in_radicand (s6_l2hc_ff),
      .in_side     (s6_side_ff),
      .out_valid   (sq_valid),
      .out_root    (sq_root),
      .out_side    (sq_side)
   );

   // Result stage: pick near or far root, clamp to range.
   logic signed [SDIST_W-1:0] dist_val;
   logic                      hit_in, sat_in;
   logic [DIST_W-1:0]         dist_in;
   logic                      rsp_hit_ff, rsp_sat_ff;
   logic [DIST_W-1:0]         rsp_dist_ff;

   always_comb begin
      dist_val = sq_side.in_sphere ? SDIST_W'(sq_side.tca) + $signed(SDIST_W'(sq_root))
                                   : SDIST_W'(sq_side.tca) - $signed(SDIST_W'(sq_root));
      hit_in  = 1'b0;
      sat_in  = 1'b0;
      dist_in = '0;
      if (!sq_side.miss) begin
         hit_in = 1'b1;
         if (dist_val < 0) begin
            sat_in = 1'b1;
         end else if (dist_val > $signed(SDIST_W'(DIST_MAX))) begin
            sat_in  = 1'b1;
            dist_in = DIST_MAX;
         end else begin
            dist_in = dist_val[DIST_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (adv) rsp_valid_ff <= sq_valid;
      if (adv) begin
         rsp_hit_ff  <= hit_in;
         rsp_sat_ff  <= sat_in;
         rsp_dist_ff <= dist_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit       = rsp_hit_ff;
   assign rsp_distance  = rsp_dist_ff;
   assign rsp_saturated = rsp_sat_ff;

`ifndef SYNTHESIS
   // A miss carries no distance and no clamp.
   a_miss_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_distance == '0 && !rsp_saturated)
      else $error("miss with nonzero distance or saturation");

   // Clamping only ever lands on one of the two range ends.
   a_sat_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |-> rsp_distance == '0 || rsp_distance == DIST_MAX)
      else $error("saturated distance not at a range end");

   // A stalled result freezes the whole pipeline, so stage 6 holds its ray.
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(s6_valid_ff) && $stable(sq_valid))
      else $error("pipeline moved while output stalled");
`endif

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench of the ray-sphere intersection core: predictor, stimulus and checks.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import rsi_pkg::*;

   // Expected outcome of one ray.
   typedef struct {
      logic                 hit;
      logic [DIST_W-1:0]    distance;
      logic                 saturated;
   } ray_outcome_type;

   class ray_scoreboard_type;
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic signed [31:0] center_z;
      logic [62:0]        radius_sq;
      ray_outcome_type    pending_outcomes[$];
      int                 mismatches;

      function new();
         center_x   = 0;
         center_y   = 0;
         center_z   = 32'sd6553600;
         radius_sq  = 63'd4294967296;
         mismatches = 0;
      endfunction

      function void report(string msg);
         $display("MISMATCH @%0t: %s", $realtime, msg);
         mismatches++;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [62:0] data);
         case (idx)
            CSR_CENTER_X: center_x = data[31:0];
            CSR_CENTER_Y: center_y = data[31:0];
            CSR_CENTER_Z: center_z = data[31:0];
            CSR_RADIUS2:  radius_sq = data;
            default: ;
         endcase
      endfunction

      // Floor square root of an 80-bit radicand.
      function logic [63:0] floor_root(logic [79:0] n);
         logic [63:0]  res;
         logic [63:0]  cand;
         logic [127:0] sq;
         res = 0;
         for (int i = 63; i >= 0; i--) begin
            cand = res | (64'd1 << i);
            sq = {64'd0, cand} * {64'd0, cand};
            if (sq <= {48'd0, n}) res = cand;
         end
         return res;
      endfunction

      // Predict the intersection of one accepted ray and queue it.
      function void note_ray(logic signed [31:0] ox, logic signed [31:0] oy,
                             logic signed [31:0] oz, logic signed [17:0] dx,
                             logic signed [17:0] dy, logic signed [17:0] dz);
         longint          oc[3];
         longint          dv[3];
         longint          dot;
         longint          mg;
         longint          tca;
         longint          dist_val;
         logic [79:0]     m;
         logic [79:0]     l2oc;
         logic [79:0]     tmag;
         logic [79:0]     tca2;
         logic [79:0]     sum;
         logic [79:0]     l2hc;
         logic [79:0]     r2;
         logic [63:0]     root;
         logic            in_sphere;
         logic            pos_hc;
         ray_outcome_type res;
         oc[0] = longint'(center_x) - longint'(ox);
         oc[1] = longint'(center_y) - longint'(oy);
         oc[2] = longint'(center_z) - longint'(oz);
         dv[0] = longint'(dx);
         dv[1] = longint'(dy);
         dv[2] = longint'(dz);
         l2oc = 0;
         dot  = 0;
         for (int i = 0; i < 3; i++) begin
            mg = (oc[i] < 0) ? -oc[i] : oc[i];
            m = 80'(mg);
            l2oc = l2oc + m * m;
            dot = dot + oc[i] * dv[i];
         end
         mg   = (dot < 0) ? -dot : dot;
         tmag = 80'((mg + 32768) >>> 16);
         tca  = (dot < 0) ? -longint'(tmag[63:0]) : longint'(tmag[63:0]);
         tca2 = tmag * tmag;
         r2   = 80'(radius_sq);
         sum  = r2 + tca2;
         pos_hc = l2oc < sum;
         l2hc = pos_hc ? sum - l2oc : 80'd0;
         in_sphere = l2oc < r2;
         res.hit = 0;
         res.distance = 0;
         res.saturated = 0;
         if (in_sphere || !(dot < 0 || !pos_hc)) begin
            root = floor_root(l2hc);
            dist_val = in_sphere ? tca + longint'(root) : tca - longint'(root);
            res.hit = 1;
            if (dist_val < 0) begin
               res.saturated = 1;
            end else if (dist_val > 64'sd2147483647) begin
               res.distance  = DIST_MAX;
               res.saturated = 1;
            end else begin
               res.distance = dist_val[30:0];
            end
         end
         pending_outcomes.push_back(res);
      endfunction

      function void check_result(logic hit, logic [DIST_W-1:0] distance,
                                 logic saturated);
         ray_outcome_type exp_o;
         if (pending_outcomes.size() == 0) begin
            report("result with no ray outstanding");
            return;
         end
         exp_o = pending_outcomes.pop_front();
         if (hit !== exp_o.hit)
            report($sformatf("hit %0b, expected %0b", hit, exp_o.hit));
         if (distance !== exp_o.distance)
            report($sformatf("distance %0d, expected %0d", distance, exp_o.distance));
         if (saturated !== exp_o.saturated)
            report($sformatf("saturated %0b, expected %0b", saturated, exp_o.saturated));
      endfunction

      function int pending();
         return pending_outcomes.size();
      endfunction
   endclass

   localparam int  DRAIN_CYCLES = 60;       // pipeline is 44 deep
   localparam int  CYCLE_LIMIT  = 2000000;

   logic clock = 0;
   logic reset = 1;

   logic                       req_valid = 0;
   logic                       req_stall;
   logic signed [COORD_W-1:0]  req_origin_x = 0;
   logic signed [COORD_W-1:0]  req_origin_y = 0;
   logic signed [COORD_W-1:0]  req_origin_z = 0;
   logic signed [DIR_W-1:0]    req_dir_x = 0;
   logic signed [DIR_W-1:0]    req_dir_y = 0;
   logic signed [DIR_W-1:0]    req_dir_z = 0;
   logic                       rsp_valid;
   logic                       rsp_stall = 0;
   logic                       rsp_hit;
   logic [DIST_W-1:0]          rsp_distance;
   logic                       rsp_saturated;
   logic                       csr_valid = 0;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index = CSR_CENTER_X;
   logic [R2_W-1:0]            csr_data = 0;

   ray_scoreboard_type sb = new();

   // Current sphere as the stimulus sees it, used to aim rays.
   real sphere_cx = 0.0, sphere_cy = 0.0, sphere_cz = 6553600.0, sphere_rad = 65536.0;
   bit  quiet_phase = 0;     // no idling on either side while set
   int  cycle_count = 0;

   always #5 clock = ~clock;

   ray_sphere_intersection_core u_top (.*);

   // Monitors: record each transaction at the edge that accepts it.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         sb.note_ray(req_origin_x, req_origin_y, req_origin_z,
                     req_dir_x, req_dir_y, req_dir_z);
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_hit, rsp_distance, rsp_saturated);
      if (!reset && csr_valid && csr_ready)
         sb.write_reg(csr_index, csr_data);
   end

   // Hard stop if the run hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Receiver backpressure: alternate runs of stall and no stall.
   int stall_left = 0;
   always @(posedge clock) begin
      if (reset || quiet_phase) begin
         rsp_stall  <= 0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else begin
         if ($urandom_range(0, 99) < 30) begin
            rsp_stall  <= 1;
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(0, 3);
         end else begin
            rsp_stall  <= 0;
            stall_left <= $urandom_range(0, 8);
         end
      end
   end

   // Mostly short gaps, a few long ones.
   function automatic int pick_gap();
      int r;
      if (quiet_phase) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Present one ray, hold it until accepted, then idle for a random gap.
   task automatic send_ray(int ox, int oy, int oz, int dx, int dy, int dz);
      int gap;
      req_valid    <= 1;
      req_origin_x <= ox;
      req_origin_y <= oy;
      req_origin_z <= oz;
      req_dir_x    <= dx[DIR_W-1:0];
      req_dir_y    <= dy[DIR_W-1:0];
      req_dir_z    <= dz[DIR_W-1:0];
      @(posedge clock);
      while (req_stall) @(posedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Hold off until every outstanding ray has returned its result.
   task automatic drain_rays();
      req_valid <= 0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [R2_W-1:0] data);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
   endtask

   // Drain, then load a new sphere.
   task automatic set_sphere(int cx, int cy, int cz, logic [62:0] r2);
      drain_rays();
      write_reg(CSR_CENTER_X, R2_W'(unsigned'(cx)));
      write_reg(CSR_CENTER_Y, R2_W'(unsigned'(cy)));
      write_reg(CSR_CENTER_Z, R2_W'(unsigned'(cz)));
      write_reg(CSR_RADIUS2, r2);
      sphere_cx  = cx;
      sphere_cy  = cy;
      sphere_cz  = cz;
      sphere_rad = $sqrt(real'(r2));
   endtask

   function automatic int clamp32(real v);
      if (v > 2147483647.0) return 32'h7fffffff;
      if (v < -2147483648.0) return 32'h80000000;
      return $rtoi(v);
   endfunction

   function automatic int clamp_dir(real v);
      if (v > 65536.0) return 65536;
      if (v < -65536.0) return -65536;
      return $rtoi(v);
   endfunction

   function automatic int rand_dir();
      return int'($urandom_range(0, 131072)) - 65536;
   endfunction

   // One random ray: mostly aimed at the sphere or starting inside it, some noise.
   task automatic random_ray();
      int  kind;
      real span, ox, oy, oz, vx, vy, vz, len, jit;
      kind = $urandom_range(0, 99);
      if (kind < 25) begin
         send_ray($urandom, $urandom, $urandom, rand_dir(), rand_dir(), rand_dir());
      end else begin
         span = (kind < 50) ? sphere_rad * 0.9 : sphere_rad * 20.0 + 65536.0;
         ox = sphere_cx + span * ($urandom_range(0, 2000) / 1000.0 - 1.0);
         oy = sphere_cy + span * ($urandom_range(0, 2000) / 1000.0 - 1.0);
         oz = sphere_cz + span * ($urandom_range(0, 2000) / 1000.0 - 1.0);
         if (kind < 50) begin
            vx = rand_dir(); vy = rand_dir(); vz = rand_dir();
         end else begin
            vx = sphere_cx - ox; vy = sphere_cy - oy; vz = sphere_cz - oz;
         end
         len = $sqrt(vx * vx + vy * vy + vz * vz);
         if (len < 1.0) len = 1.0;
         jit = (kind < 80) ? 0.0 : 0.3;
         send_ray(clamp32(ox), clamp32(oy), clamp32(oz),
                  clamp_dir(65536.0 * (vx / len + jit * ($urandom_range(0, 200) / 100.0 - 1.0))),
                  clamp_dir(65536.0 * (vy / len + jit * ($urandom_range(0, 200) / 100.0 - 1.0))),
                  clamp_dir(65536.0 * (vz / len + jit * ($urandom_range(0, 200) / 100.0 - 1.0))));
      end
   endtask

   localparam int MAXP = 32'h7fffffff;
   localparam int MINN = 32'h80000000;
   localparam int UNIT = 65536;

   initial begin
      int          rad_q;
      logic [62:0] r2;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed rays against the reset sphere: unit radius at z = 100.
      quiet_phase = 1;
      send_ray(0, 0, 0, 0, 0, UNIT);                          // straight hit
      send_ray(0, 0, 0, 0, 0, -UNIT);                         // pointing away
      send_ray(0, 0, 100 * UNIT, 0, 0, UNIT);                 // origin at center
      send_ray(0, 0, 100 * UNIT, UNIT, UNIT, UNIT);           // inside, non-unit dir
      send_ray(UNIT, 0, 0, 0, 0, UNIT);                       // grazing, zero half-chord
      send_ray(0, 0, 0, 0, 0, 0);                             // zero direction
      quiet_phase = 0;
      send_ray(45000, 45000, 100 * UNIT, UNIT, UNIT, 0);      // inside, heading out
      send_ray(MAXP, MAXP, MAXP, UNIT, UNIT, UNIT);
      send_ray(MINN, MINN, MINN, -UNIT, -UNIT, -UNIT);
      send_ray(MINN, MAXP, MINN, UNIT, -UNIT, UNIT);
      send_ray(MAXP, MINN, MAXP, -UNIT, UNIT, -UNIT);

      // Extreme sphere: far corner, largest radius, so distances clamp.
      set_sphere(MAXP, MINN, MAXP, {63{1'b1}});
      send_ray(MINN, MAXP, MINN, UNIT, -UNIT, UNIT);
      send_ray(MINN, MAXP, MINN, -UNIT, UNIT, -UNIT);
      send_ray(0, 0, 0, 37837, -37837, 37837);
      send_ray(MAXP, MINN, MAXP, 0, 0, 0);

      // Degenerate sphere of zero radius.
      set_sphere(0, 0, 0, 63'd0);
      send_ray(0, 0, -10 * UNIT, 0, 0, UNIT);
      send_ray(0, 0, 0, 0, 0, UNIT);
      send_ray(5, 7, -3, UNIT, 0, 0);

      // Random phases, each with its own sphere.
      for (int ph = 0; ph < 6; ph++) begin
         if (ph == 5) begin
            r2 = 63'({$urandom, $urandom});
            set_sphere($urandom, $urandom, $urandom, r2);
         end else begin
            rad_q = $urandom_range(32768, 300 * UNIT);
            r2 = 63'(longint'(rad_q) * longint'(rad_q));
            set_sphere(int'($urandom_range(0, 131072000)) - 65536000,
                       int'($urandom_range(0, 131072000)) - 65536000,
                       int'($urandom_range(0, 131072000)) - 65536000, r2);
         end
         quiet_phase = (ph == 2);
         for (int n = 0; n < 280; n++) begin
            if (ph == 3 && n == 140) drain_rays();   // sender waits for a full drain
            random_ray();
         end
         quiet_phase = 0;
      end

      drain_rays();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end
endmodule

// ===== filelist.f =====
sv/rsi_pkg.sv
sv/rsi_isqrt.sv
sv/ray_sphere_intersection_core.sv
dv/tb_top.sv
